@@ src/qaw_pkg.sv @@
package qaw_pkg;

  // Grid size per axis
  localparam int BINS_ANGLE    = 8;
  localparam int BINS_MOMENTUM = 8;
  localparam int BINS_Z        = 8;
  localparam int BINS_THETA    = 8;

  localparam int IA_W = $clog2(BINS_ANGLE);
  localparam int IP_W = $clog2(BINS_MOMENTUM);
  localparam int IZ_W = $clog2(BINS_Z);
  localparam int IT_W = $clog2(BINS_THETA);

  // Limit table: two words (lower, upper) per grid point
  localparam int TABLE_DEPTH = 8192;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // Address strides per axis
  localparam int STRIDE_T = 2;
  localparam int STRIDE_Z = STRIDE_T * BINS_THETA;
  localparam int STRIDE_P = STRIDE_Z * BINS_Z;
  localparam int STRIDE_A = STRIDE_P * BINS_MOMENTUM;

  // -180/pi in Q16.16
  localparam logic signed [23:0] NEG_DEG_PER_RAD = -24'sd3754936;

  // Config register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_MOMENTUM = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_VERTEX_Z = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_POLAR    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_ANGLE      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MOMENTUM   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_VERTEX_Z   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INV_POLAR      = 4'd7;

  localparam logic [31:0] INV_STEP_RESET = 32'd65536;

  // Axis order in the front sequencer
  localparam logic [1:0] AX_ANGLE    = 2'd0;
  localparam logic [1:0] AX_MOMENTUM = 2'd1;
  localparam logic [1:0] AX_Z        = 2'd2;
  localparam logic [1:0] AX_THETA    = 2'd3;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IN_GRID   = 2'd0,
    ST_ANGLE_OUT = 2'd1,
    ST_MOM_OUT   = 2'd2,
    ST_THETA_OUT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    JOB_LOAD,
    JOB_QUERY,
    JOB_REJECT
  } job_kind_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DEG1,
    F_DEG2,
    F_SUB,
    F_MUL,
    F_CHK
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_WAIT
  } back_state_t;

  typedef struct packed {
    logic               mode;
    logic [12:0]        entry_address;
    logic signed [31:0] entry_value;
    logic signed [31:0] angle_rad;
    logic signed [31:0] momentum_dev;
    logic signed [31:0] vertex_z;
    logic signed [31:0] polar;
    logic signed [31:0] azimuth;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    status_t            status;
    logic               z_clamped;
    logic signed [31:0] lower_limit;
    logic signed [31:0] upper_limit;
  } out_item_t;

  // Work handed from front to back
  typedef struct packed {
    job_kind_t          kind;
    logic [ADDR_W-1:0]  waddr;
    logic signed [31:0] value;   // load data, or azimuth for a query
    status_t            status;
    logic               zc;
    logic [ADDR_W-1:0]  base;
    logic [3:0][15:0]   wts;     // theta, z, momentum, angle
  } job_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

@@ src/qaw_lerp_stage.sv @@
module qaw_lerp_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [31:0] in_val,
  input  logic [15:0]        wt,
  output logic               out_vld,
  output logic signed [31:0] out_val
);
  import qaw_pkg::*;

  logic               have_r;
  logic signed [31:0] hold_r;
  logic               mv_r;
  logic signed [49:0] m0_r, m1_r;
  logic [16:0]        wc;
  logic signed [50:0] sum;

  assign wc = 17'd65536 - {1'b0, wt};

  // Pair up values; second of a pair fires the products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      mv_r   <= 1'b0;
    end else begin
      mv_r <= in_vld && have_r;
      if (in_vld) have_r <= !have_r;
    end
    if (in_vld && !have_r) hold_r <= in_val;
    if (in_vld && have_r) begin
      m0_r <= hold_r * $signed({1'b0, wc});
      m1_r <= in_val * $signed({2'b0, wt});
    end
  end

  // Round and floor by 2^16
  assign sum     = 51'(m0_r) + 51'(m1_r) + 51'sd32768;
  assign out_vld = mv_r;
  assign out_val = sum[47:16];

endmodule

@@ src/qaw_queue.sv @@
module qaw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  qaw_pkg::job_t  push_job,
  input  logic           pop,
  output qaw_pkg::job_t  head,
  output logic           full,
  output logic           empty
);
  import qaw_pkg::*;

  job_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) q_r[wr_ptr_r] <= push_job;
  end

  assign head  = q_r[rd_ptr_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

endmodule

@@ src/qaw_front.sv @@
module qaw_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  qaw_pkg::in_item_t               in_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [qaw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data,
  output logic                            push,
  output qaw_pkg::job_t                   push_job,
  input  logic                            q_full
);
  import qaw_pkg::*;

  front_state_t state_r, state_nxt;

  logic signed [31:0] start_a_r, start_p_r, start_z_r, start_t_r;
  logic [31:0]        inv_a_r, inv_p_r, inv_z_r, inv_t_r;

  in_item_t           item_r;
  logic signed [55:0] prod_r;
  logic signed [31:0] deg_r, d_r;
  logic signed [63:0] p_r;
  logic [1:0]         axis_r;
  logic [IA_W-1:0]    ia_r;
  logic [IP_W-1:0]    ip_r;
  logic [IZ_W-1:0]    iz_r;
  logic               zc_r;
  logic [3:0][15:0]   wts_r;

  logic               accept;
  logic signed [31:0] x_sel, s_sel;
  logic [31:0]        inv_sel;
  logic signed [55:0] deg_t;
  logic signed [31:0] idx_s;
  logic [15:0]        w_cur;
  logic               below, above;
  logic [ADDR_W-1:0]  cell_idx;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != F_IDLE) || q_full;
  assign accept    = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_a_r <= '0;
      start_p_r <= '0;
      start_z_r <= '0;
      start_t_r <= '0;
      inv_a_r   <= INV_STEP_RESET;
      inv_p_r   <= INV_STEP_RESET;
      inv_z_r   <= INV_STEP_RESET;
      inv_t_r   <= INV_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_ANGLE:    start_a_r <= cfg_data;
        REG_START_MOMENTUM: start_p_r <= cfg_data;
        REG_START_VERTEX_Z: start_z_r <= cfg_data;
        REG_START_POLAR:    start_t_r <= cfg_data;
        REG_INV_ANGLE:      inv_a_r   <= cfg_data;
        REG_INV_MOMENTUM:   inv_p_r   <= cfg_data;
        REG_INV_VERTEX_Z:   inv_z_r   <= cfg_data;
        REG_INV_POLAR:      inv_t_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Axis operand select
  always_comb begin
    case (axis_r)
      AX_ANGLE:    begin x_sel = deg_r;              s_sel = start_a_r; inv_sel = inv_a_r; end
      AX_MOMENTUM: begin x_sel = item_r.momentum_dev; s_sel = start_p_r; inv_sel = inv_p_r; end
      AX_Z:        begin x_sel = item_r.vertex_z;     s_sel = start_z_r; inv_sel = inv_z_r; end
      default:     begin x_sel = item_r.polar;        s_sel = start_t_r; inv_sel = inv_t_r; end
    endcase
  end

  assign deg_t = (prod_r + 56'sd32768) >>> 16;
  assign idx_s = p_r[63:32];
  assign w_cur = p_r[31:16];
  assign below = idx_s < 32'sd0;

  always_comb begin
    case (axis_r)
      AX_ANGLE:    above = idx_s >= 32'(BINS_ANGLE - 1);
      AX_MOMENTUM: above = idx_s >= 32'(BINS_MOMENTUM - 1);
      AX_Z:        above = idx_s >= 32'(BINS_Z - 1);
      default:     above = idx_s >= 32'(BINS_THETA - 1);
    endcase
  end

  // Cell index of the lower corner, theta index taken live
  assign cell_idx = ADDR_W'(((ia_r * BINS_MOMENTUM + ip_r) * BINS_Z + iz_r) * BINS_THETA
                            + idx_s[IT_W-1:0]);

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) item_r <= in_item;
    case (state_r)
      F_DEG1: prod_r <= item_r.angle_rad * NEG_DEG_PER_RAD;
      F_DEG2: deg_r  <= sat32(64'(deg_t));
      F_SUB:  d_r    <= sat32(64'(x_sel) - 64'(s_sel));
      F_MUL:  p_r    <= 64'(d_r * $signed({1'b0, inv_sel}));
      F_CHK: begin
        wts_r[2'd3 - axis_r] <= w_cur;
        case (axis_r)
          AX_ANGLE:    ia_r <= idx_s[IA_W-1:0];
          AX_MOMENTUM: ip_r <= idx_s[IP_W-1:0];
          AX_Z: begin
            zc_r <= below || above;
            if (below) iz_r <= '0;
            else if (above) iz_r <= IZ_W'(BINS_Z - 2);
            else iz_r <= idx_s[IZ_W-1:0];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Axis counter
  always_ff @(posedge clk) begin
    if (!rst_n) axis_r <= AX_ANGLE;
    else if (state_r == F_DEG2) axis_r <= AX_ANGLE;
    else if (state_r == F_CHK && !(below || above) && axis_r != AX_THETA) axis_r <= axis_r + 2'd1;
    else if (state_r == F_CHK && axis_r == AX_Z) axis_r <= axis_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else state_r <= state_nxt;
  end

  // Sequencer and queue push
  always_comb begin
    state_nxt      = state_r;
    push           = 1'b0;
    push_job       = '0;
    push_job.kind  = JOB_LOAD;
    push_job.waddr = in_item.entry_address;
    push_job.value = in_item.entry_value;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (in_item.mode == MODE_LOAD) push = 1'b1;
          else state_nxt = F_DEG1;
        end
      end
      F_DEG1: state_nxt = F_DEG2;
      F_DEG2: state_nxt = F_SUB;
      F_SUB:  state_nxt = F_MUL;
      F_MUL:  state_nxt = F_CHK;
      F_CHK: begin
        if (axis_r == AX_Z) begin
          state_nxt = F_SUB;
        end else if (below || above) begin
          push_job.kind = JOB_REJECT;
          case (axis_r)
            AX_ANGLE:    push_job.status = ST_ANGLE_OUT;
            AX_MOMENTUM: push_job.status = ST_MOM_OUT;
            default:     push_job.status = ST_THETA_OUT;
          endcase
          if (!q_full) begin
            push      = 1'b1;
            state_nxt = F_IDLE;
          end
        end else if (axis_r == AX_THETA) begin
          push_job.kind   = JOB_QUERY;
          push_job.value  = item_r.azimuth;
          push_job.status = ST_IN_GRID;
          push_job.zc     = zc_r;
          push_job.base   = ADDR_W'({cell_idx, 1'b0});
          push_job.wts    = {wts_r[3:1], w_cur};
          if (!q_full) begin
            push      = 1'b1;
            state_nxt = F_IDLE;
          end
        end else begin
          state_nxt = F_SUB;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
    else $error("push into full queue");
  a_query_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_job.kind == JOB_QUERY) |-> (axis_r == AX_THETA))
    else $error("query pushed before all axes done");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ($past(in_item.mode) == MODE_LOAD) || (state_r == F_DEG1))
    else $error("query not started");

endmodule

@@ src/qaw_back.sv @@
module qaw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  qaw_pkg::job_t       head,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_strobe,
  output qaw_pkg::out_item_t  out_item
);
  import qaw_pkg::*;

  back_state_t state_r, state_nxt;

  logic [31:0]        mem [TABLE_DEPTH];
  job_t               job_r;
  logic [4:0]         cnt_r;
  logic               rvld_r;
  logic signed [31:0] rdata_r;
  logic signed [31:0] lo_r;
  logic               fin_cnt_r;
  logic               out_strobe_r;
  out_item_t          out_item_r;

  logic               re;
  logic [ADDR_W-1:0]  raddr;
  logic [3:0]         k;
  logic               lvl_vld [5];
  logic signed [31:0] lvl_val [5];
  logic               fin_vld;
  logic signed [31:0] fin_val;

  // Corner address: bit 0 of k walks theta, bit 3 walks angle; bit 4 picks the limit
  assign k     = cnt_r[3:0];
  assign raddr = job_r.base
               + (k[3] ? ADDR_W'(STRIDE_A) : '0)
               + (k[2] ? ADDR_W'(STRIDE_P) : '0)
               + (k[1] ? ADDR_W'(STRIDE_Z) : '0)
               + (k[0] ? ADDR_W'(STRIDE_T) : '0)
               + ADDR_W'(cnt_r[4]);

  // Limit table
  always_ff @(posedge clk) begin
    if (pop && head.kind == JOB_LOAD) mem[head.waddr] <= head.value;
    if (re) rdata_r <= mem[raddr];
  end

  // Reduction tree: theta, z, momentum, angle
  assign lvl_vld[0] = rvld_r;
  assign lvl_val[0] = rdata_r;
  for (genvar g = 0; g < 4; g++) begin : g_lvl
    qaw_lerp_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (lvl_vld[g]),
      .in_val  (lvl_val[g]),
      .wt      (job_r.wts[g]),
      .out_vld (lvl_vld[g+1]),
      .out_val (lvl_val[g+1])
    );
  end
  assign fin_vld = lvl_vld[4];
  assign fin_val = lvl_val[4];

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    re        = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (head.kind == JOB_QUERY) state_nxt = B_READ;
        end
      end
      B_READ: begin
        re = 1'b1;
        if (cnt_r == 5'd31) state_nxt = B_WAIT;
      end
      B_WAIT: begin
        if (fin_vld && fin_cnt_r) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      rvld_r       <= 1'b0;
      fin_cnt_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      rvld_r       <= re;
      out_strobe_r <= (pop && head.kind == JOB_REJECT) || (fin_vld && fin_cnt_r);
      if (state_r == B_IDLE) cnt_r <= '0;
      else if (re) cnt_r <= cnt_r + 5'd1;
      if (fin_vld) fin_cnt_r <= !fin_cnt_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) job_r <= head;
    if (fin_vld && !fin_cnt_r) lo_r <= fin_val;
    if (pop && head.kind == JOB_REJECT) begin
      out_item_r <= '{accepted: 1'b0, status: head.status, z_clamped: 1'b0,
                      lower_limit: 32'sd0, upper_limit: 32'sd0};
    end else if (fin_vld && fin_cnt_r) begin
      out_item_r.accepted    <= (lo_r < job_r.value) && (job_r.value < fin_val);
      out_item_r.status      <= ST_IN_GRID;
      out_item_r.z_clamped   <= job_r.zc;
      out_item_r.lower_limit <= lo_r;
      out_item_r.upper_limit <= fin_val;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == B_IDLE) && !q_empty)
    else $error("pop outside idle");
  a_read_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_READ) |=> rvld_r)
    else $error("table read lost");
  a_fin_state: assert property (@(posedge clk) disable iff (!rst_n)
    fin_vld |-> (state_r == B_READ) || (state_r == B_WAIT))
    else $error("limit finished outside a query");

endmodule

@@ src/quadrilinear_acceptance_window_unit.sv @@
// Query: from its accept edge the front converts the angle to degrees, then works each axis
// in turn; the idle back end pops the job, makes 32 single-port table reads and drains the
// lerp tree to the result strobe. Throughput is set by the table reads; busy holds start off
// while the front works a query or the 2-entry queue is full. Rejects strobe when popped.
// Load: one per cycle while busy is low; written when the load leaves the queue, in order.
// Synchronous active-low reset clears control and config; table undefined until loaded.
module quadrilinear_acceptance_window_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  qaw_pkg::in_item_t               in_item,
  output logic                            out_strobe,
  output qaw_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [qaw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import qaw_pkg::*;

  logic push, pop, q_full, q_empty;
  job_t push_job, head;

  qaw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  qaw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  qaw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qaw_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  // Predicts window results and holds the results still due
  class window_scoreboard;
    logic signed [31:0] limits [TABLE_DEPTH];
    bit known [TABLE_DEPTH];
    longint org [4];
    logic [31:0] rcp [4];
    out_item_t due_q [$];
    int errors;

    function new();
      for (int i = 0; i < 4; i++) begin
        org[i] = 0;
        rcp[i] = INV_STEP_RESET;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx <= REG_START_POLAR) org[idx[1:0]] = longint'($signed(data));
      else if (idx <= REG_INV_POLAR) rcp[idx[1:0]] = data;
    endfunction

    function longint clip(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // cell index and Q0.16 weight along one axis
    function longint grid_pos(longint x, longint s, logic [31:0] inv, output logic [15:0] w);
      logic signed [63:0] p;
      p = clip(x - s) * longint'({32'b0, inv});
      w = p[31:16];
      return longint'($signed(p[63:32]));
    endfunction

    function longint blend(longint v0, longint v1, logic [15:0] w);
      return (v0 * (65536 - longint'(w)) + v1 * longint'(w) + 32768) >>> 16;
    endfunction

    // 16 corner reads, reduced theta first, then z, momentum, angle
    function longint corners(int base, logic [15:0] wts [4]);
      longint v [16];
      int a;
      int n;
      for (int k = 0; k < 16; k++) begin
        a = base;
        if (k & 8) a += STRIDE_A;
        if (k & 4) a += STRIDE_P;
        if (k & 2) a += STRIDE_Z;
        if (k & 1) a += STRIDE_T;
        v[k] = (a < TABLE_DEPTH) ? longint'(limits[a]) : 0;
      end
      n = 16;
      for (int lvl = 0; lvl < 4; lvl++) begin
        n = n / 2;
        for (int k = 0; k < n; k++) v[k] = blend(v[2*k], v[2*k+1], wts[lvl]);
      end
      return v[0];
    endfunction

    // Grid checks of a query; 1 when it goes on to read the table
    function bit locate(in_item_t it, output out_item_t r, output int base,
                        output logic [15:0] wts [4]);
      longint deg, ia, ip, iz, it_t;
      r = '0;
      base = 0;
      r.status = ST_IN_GRID;
      deg = clip((longint'(it.angle_rad) * -64'sd3754936 + 32768) >>> 16);
      ia = grid_pos(deg, org[0], rcp[0], wts[3]);
      if (ia < 0 || ia >= BINS_ANGLE - 1) begin
        r.status = ST_ANGLE_OUT;
        return 1'b0;
      end
      ip = grid_pos(longint'(it.momentum_dev), org[1], rcp[1], wts[2]);
      if (ip < 0 || ip >= BINS_MOMENTUM - 1) begin
        r.status = ST_MOM_OUT;
        return 1'b0;
      end
      iz = grid_pos(longint'(it.vertex_z), org[2], rcp[2], wts[1]);
      if (iz < 0) begin
        iz = 0;
        r.z_clamped = 1'b1;
      end else if (iz >= BINS_Z - 1) begin
        iz = BINS_Z - 2;
        r.z_clamped = 1'b1;
      end
      it_t = grid_pos(longint'(it.polar), org[3], rcp[3], wts[0]);
      if (it_t < 0 || it_t >= BINS_THETA - 1) begin
        r = '0;
        r.status = ST_THETA_OUT;
        return 1'b0;
      end
      base = int'(2 * ((((ia * BINS_MOMENTUM) + ip) * BINS_Z + iz) * BINS_THETA + it_t));
      return 1'b1;
    endfunction

    // 1 unless the item is a query that would read a word never loaded
    function bit safe(in_item_t it);
      out_item_t r;
      int base;
      logic [15:0] wts [4];
      int a;
      if (it.mode == MODE_LOAD) return 1'b1;
      if (!locate(it, r, base, wts)) return 1'b1;
      for (int k = 0; k < 32; k++) begin
        a = base;
        if (k & 16) a += 1;
        if (k & 8) a += STRIDE_A;
        if (k & 4) a += STRIDE_P;
        if (k & 2) a += STRIDE_Z;
        if (k & 1) a += STRIDE_T;
        if (a < TABLE_DEPTH && !known[a]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note(in_item_t it);
      out_item_t r;
      longint lo, hi, ph;
      logic [15:0] wts [4];
      int base;
      if (it.mode == MODE_LOAD) begin
        limits[it.entry_address] = it.entry_value;
        known[it.entry_address] = 1'b1;
        return;
      end
      if (locate(it, r, base, wts)) begin
        lo = corners(base, wts);
        hi = corners(base + 1, wts);
        ph = longint'(it.azimuth);
        r.accepted = (lo < ph && ph < hi);
        r.lower_limit = lo[31:0];
        r.upper_limit = hi[31:0];
      end
      due_q.push_back(r);
    endfunction

    function void check(out_item_t got);
      out_item_t exp_r;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = due_q.pop_front();
      if (got.accepted !== exp_r.accepted || got.status !== exp_r.status ||
          got.z_clamped !== exp_r.z_clamped || got.lower_limit !== exp_r.lower_limit ||
          got.upper_limit !== exp_r.upper_limit) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_strobe;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  window_scoreboard sb = new();
  int idle_pct = 34;
  int stall_count = 0;
  bit progress;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quadrilinear_acceptance_window_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Result monitor and stall watchdog
  always @(posedge clk) begin
    progress = (start && !busy) || (cfg_valid && cfg_ready);
    if (rst_n && out_strobe) begin
      sb.check(out_item);
      progress = 1'b1;
    end
    if (!rst_n || progress) stall_count = 0;
    else stall_count++;
    if (stall_count >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(in_item_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note(it);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  // Full register set; block must be idle
  task automatic setup(logic [31:0] s [4], logic [31:0] inv [4]);
    for (int i = 0; i < 4; i++) write_reg(CFG_IDX_W'(REG_START_ANGLE + i), s[i]);
    for (int i = 0; i < 4; i++) write_reg(CFG_IDX_W'(REG_INV_ANGLE + i), inv[i]);
    write_reg(CFG_IDX_W'($urandom_range(8, 15)), $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_rcp();
    case ($urandom_range(3))
      0: return $urandom_range(4096, 262144);
      1: return 32'd1;
      2: return 32'hffffffff;
      default: return ($urandom == 0) ? 32'd1 : $urandom;
    endcase
  endfunction

  // Coordinate landing inside the first cells of one axis
  function automatic logic [31:0] in_grid(int ax, int cells);
    longint span;
    longint r;
    span = (longint'(cells) << 32) / longint'({32'b0, sb.rcp[ax]});
    if (span > 64'sd2147483647) span = 64'sd2147483647;
    if (span < 1) span = 1;
    r = longint'({$urandom, $urandom} % longint'(span));
    return 32'(sb.clip(sb.org[ax] + r));
  endfunction

  function automatic in_item_t make_query(logic [31:0] a, logic [31:0] m, logic [31:0] z,
                                         logic [31:0] t, logic [31:0] phi);
    in_item_t it;
    it = '0;
    it.mode = MODE_QUERY;
    it.entry_address = ADDR_W'($urandom);
    it.entry_value = $urandom;
    it.angle_rad = a;
    it.momentum_dev = m;
    it.vertex_z = z;
    it.polar = t;
    it.azimuth = phi;
    return it;
  endfunction

  function automatic in_item_t make_load(logic [12:0] addr, logic [31:0] val);
    in_item_t it;
    it = make_query($urandom, $urandom, $urandom, $urandom, $urandom);
    it.mode = MODE_LOAD;
    it.entry_address = addr;
    it.entry_value = val;
    return it;
  endfunction

  function automatic logic [31:0] rad_for(longint deg);
    return 32'(sb.clip(-(deg * 65536) / 3754936));
  endfunction

  function automatic in_item_t rand_item();
    logic [31:0] c [4];
    longint phi;
    if ($urandom_range(99) < 30)
      return make_load(ADDR_W'($urandom), ($urandom_range(3) == 0) ? $urandom :
                       $signed($urandom_range(0, 13107200)) - 32'sd6553600);
    if ($urandom_range(99) < 15)
      return make_query($urandom, $urandom, $urandom, $urandom, $urandom);
    c[0] = rad_for(longint'($signed(in_grid(0, 1))));
    for (int i = 1; i < 4; i++) c[i] = in_grid(i, (i < 2) ? 1 : 7);
    for (int i = 0; i < 4; i++) if ($urandom_range(99) < 8) c[i] = $urandom;
    phi = longint'($urandom_range(0, 19660800)) - 7864320;
    return make_query(c[0], c[1], c[2], c[3], ($urandom_range(19) == 0) ? $urandom : phi);
  endfunction

  // Random item that reads only loaded table words
  function automatic in_item_t pick_item();
    in_item_t it;
    do it = rand_item(); while (!sb.safe(it));
    return it;
  endfunction

  initial begin
    logic [31:0] s [4];
    logic [31:0] inv [4];
    logic signed [31:0] lo;
    int a;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default register values
    for (int i = 0; i < 4; i++) begin
      s[i] = 0;
      inv[i] = INV_STEP_RESET;
    end
    setup(s, inv);

    // fill first two angle and momentum cells over all z and theta: lower, then upper
    for (int ia = 0; ia < 2; ia++) begin
      for (int ip = 0; ip < 2; ip++) begin
        for (int pt = 0; pt < BINS_Z * BINS_THETA; pt++) begin
          a = ia * STRIDE_A + ip * STRIDE_P + pt * STRIDE_T;
          lo = ($urandom_range(15) == 0) ? $urandom :
               $signed($urandom_range(0, 13107200)) - 32'sd6553600;
          send(make_load(ADDR_W'(a), lo));
          send(make_load(ADDR_W'(a + 1), ($urandom_range(15) == 0) ? $urandom :
                         lo + $signed($urandom_range(0, 3276800))));
        end
      end
    end

    // directed: field extremes and each rejection path
    send(make_load(0, 32'h80000000));
    send(make_load(1, 32'h7fffffff));
    send(make_load(TABLE_DEPTH - 1, 32'h7fffffff));
    send(make_load(TABLE_DEPTH - 2, 32'h80000000));
    send(make_query(rad_for(32768), 32'h8000, 32'h8000, 32'h8000, 0));
    send(make_query(rad_for(0), 0, 0, 0, 32'h80000000));
    send(make_query(rad_for(65535), 32'hffff, 32'h6ffff, 32'h6ffff, 32'h7fffffff));
    send(make_query(32'h7fffffff, 0, 0, 0, 0));
    send(make_query(32'h80000000, 0, 0, 0, 0));
    send(make_query(rad_for(-65536), 0, 0, 0, 0));
    send(make_query(rad_for(3 * 65536), 32'h80000000, 0, 0, 0));
    send(make_query(rad_for(3 * 65536), 32'h7fffffff, 0, 0, 0));
    send(make_query(rad_for(3 * 65536), 32'h70000, 0, 0, 0));
    send(make_query(rad_for(32768), 32'h8000, 32'h80000000, 32'h10000, 0));
    send(make_query(rad_for(32768), 32'h8000, 32'h7fffffff, 32'h10000, 32'h18000));
    send(make_query(rad_for(32768), 32'h8000, 32'h90000, 32'h70000, 0));
    send(make_query(rad_for(3 * 65536), 32'h10000, 32'h10000, 32'h80000000, 0));
    send(make_query(rad_for(3 * 65536), 32'h10000, 32'hffff0000, 32'h7fffffff, 0));
    drain();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < 4; i++) begin
        case (ph)
          0: begin s[i] = 0; inv[i] = INV_STEP_RESET; end
          1: begin
            s[i] = $signed($urandom_range(0, 6553600)) - 32'sd3276800;
            inv[i] = $urandom_range(4096, 262144);
          end
          2: begin s[i] = 32'h80000000; inv[i] = 32'd1; end
          3: begin s[i] = 32'h7fffffff; inv[i] = 32'hffffffff; end
          default: begin s[i] = $urandom; inv[i] = rand_rcp(); end
        endcase
      end
      setup(s, inv);
      for (int n = 0; n < 115; n++) begin
        idle_pct = (ph == 1 && n >= 20 && n < 80) ? 0 : 34;
        if (ph == 4 && n == 55) drain();
        send(pick_item());
      end
      drain();
    end

    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

@@ files.f @@
src/qaw_pkg.sv
src/qaw_lerp_stage.sv
src/qaw_queue.sv
src/qaw_front.sv
src/qaw_back.sv
src/quadrilinear_acceptance_window_unit.sv
tb/sv/testbench.sv
